/* src/assert_macros.svh */
// Assertion macros used by the checker file of the telemetry framer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* src/tfb_pkg.sv */
// Package for the telemetry frame builder: sizes, header byte and register map.
// No dependencies.
package tfb_pkg;

	localparam int unsigned MAX_PAYLOAD = 80;
	localparam int unsigned MAX_RESULTS = 12;
	localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [2:0] ELEM_BYTES_RESET = 3'd4;
	localparam logic [2:0] ELEM_BYTES_MAX = 3'd4;

	// Register index as seen in bit 2 of the byte address.
	localparam logic REG_ELEMENT_BYTES = 1'b0;

	typedef logic [7:0] byte_buf_t [MAX_RESULTS];

endpackage

/* src/telemetry_frame_builder.sv */
// Telemetry frame builder: top level, turns payload elements into framed bytes.
// Depends on tfb_pkg.
//
// The input channel (in_valid, in_stall) carries one payload element per transfer
// together with a function code and payload length; the last two are only used by
// the transfer that opens a frame. The output channel (out_valid, out_stall)
// carries one frame byte per transfer, with frame_end marking the checksum and
// run_last marking the last byte produced by an input transfer.
// An accepted item is held in an input register, then expanded in a single
// combinational pass into a byte buffer of up to twelve entries, which is shifted
// out one byte per cycle while the receiver does not stall. The first byte is
// offered once the item has passed the input register and been loaded into the
// buffer. The single output byte lane sets the flow: an item yields four bytes for
// a four-byte element in mid-frame, up to twelve when it opens and closes a frame.
// The next item is taken into the input register while the buffer still drains,
// so that it is ready to load on the cycle the last byte leaves.
// An opening item with a length above the maximum is discarded without output.
// When the receiver stalls, the current byte is held and the input side fills and
// then stalls in turn. Reset empties the pipeline, closes any open frame and sets
// the element size register to four bytes.
// The element size register sits at byte addresses 0 to 3 of the APB port;
// values of 0 act as 1 and values above 4 act as 4.
module telemetry_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  func_code,
	input  logic [7:0]  payload_len,
	input  logic [31:0] element,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration register.
	logic [2:0] element_bytes_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  func_code_s1;
	logic [7:0]  payload_len_s1;
	logic [31:0] element_s1;

	// Frame state.
	logic       in_frame_q;
	logic [6:0] bytes_done_q;
	logic [7:0] running_sum_q;
	logic [6:0] frame_length_q;

	// Output byte buffer.
	tfb_pkg::byte_buf_t          buf_q;
	logic [tfb_pkg::CNT_W-1:0]   count_q;
	logic                        close_q;

	// Pass results.
	tfb_pkg::byte_buf_t          buf_d;
	logic [tfb_pkg::CNT_W-1:0]   count_d;
	logic                        opening;
	logic                        drop;
	logic [2:0]                  eb;
	logic [6:0]                  flen;
	logic [6:0]                  bdone;
	logic [7:0]                  sum0;
	logic [6:0]                  rem;
	logic [6:0]                  rem2;
	logic                        has_elem;
	logic                        close;
	logic [1:0]                  nz;
	logic [7:0]                  elem_sum;
	logic [7:0]                  sum1;
	logic [3:0]                  hn;
	logic [3:0]                  e_end;
	logic [3:0]                  z_end;

	// Handshake terms.
	logic take;
	logic buf_free;
	logic s1_drain;
	logic load;
	logic cfg_wr;

	assign take      = out_valid && !out_stall;
	assign buf_free  = (count_q == '0) || ((count_q == tfb_pkg::CNT_W'(1)) && take);
	assign drop      = opening && (payload_len_s1 > 8'(tfb_pkg::MAX_PAYLOAD));
	assign s1_drain  = valid_s1 && (drop || buf_free);
	assign load      = valid_s1 && !drop && buf_free;
	assign in_stall  = valid_s1 && !s1_drain;

	assign out_valid = (count_q != '0);
	assign out_byte  = buf_q[0];
	assign run_last  = (count_q == tfb_pkg::CNT_W'(1));
	assign frame_end = run_last && close_q;

	assign pready = 1'b1;
	assign prdata = {29'd0, element_bytes_q};
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == tfb_pkg::REG_ELEMENT_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_bytes_q <= tfb_pkg::ELEM_BYTES_RESET;
		end else if (cfg_wr) begin
			element_bytes_q <= pwdata[2:0];
		end
	end

	// Single pass: work out how many header, element, fill and checksum bytes the
	// item in the input register produces, and lay them out in order.
	always_comb begin
		logic [3:0] j;
		logic [3:0] lane4;
		logic [1:0] lane;

		if (element_bytes_q == 3'd0) begin
			eb = 3'd1;
		end else if (element_bytes_q > tfb_pkg::ELEM_BYTES_MAX) begin
			eb = tfb_pkg::ELEM_BYTES_MAX;
		end else begin
			eb = element_bytes_q;
		end

		opening = !in_frame_q;
		flen    = opening ? payload_len_s1[6:0] : frame_length_q;
		bdone   = opening ? 7'd0 : bytes_done_q;
		sum0    = opening ? 8'(tfb_pkg::HEADER_BYTE + tfb_pkg::HEADER_BYTE
			+ func_code_s1 + payload_len_s1) : running_sum_q;

		rem      = (flen >= bdone) ? (flen - bdone) : 7'd0;
		has_elem = (rem >= {4'd0, eb});
		rem2     = has_elem ? (rem - {4'd0, eb}) : rem;
		close    = (rem2 < {4'd0, eb});
		nz       = close ? rem2[1:0] : 2'd0;

		// Sum of the bytes of the element that are in use.
		elem_sum = 8'd0;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < eb) begin
				elem_sum = elem_sum + element_s1[8*k +: 8];
			end
		end
		sum1 = has_elem ? (sum0 + elem_sum) : sum0;

		hn      = opening ? 4'd4 : 4'd0;
		e_end   = hn + (has_elem ? {1'b0, eb} : 4'd0);
		z_end   = e_end + {2'b00, nz};
		count_d = tfb_pkg::CNT_W'(z_end + {3'd0, close});

		for (int p = 0; p < tfb_pkg::MAX_RESULTS; p++) begin
			j     = 4'(p) - hn;
			lane4 = {1'b0, eb} - 4'd1 - j;
			lane  = lane4[1:0];
			if (4'(p) < hn) begin
				case (p)
					2:       buf_d[p] = func_code_s1;
					3:       buf_d[p] = payload_len_s1;
					default: buf_d[p] = tfb_pkg::HEADER_BYTE;
				endcase
			end else if (4'(p) < e_end) begin
				buf_d[p] = element_s1[8*lane +: 8];
			end else if (4'(p) < z_end) begin
				buf_d[p] = 8'd0;
			end else begin
				buf_d[p] = sum1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_code_s1   <= func_code;
			payload_len_s1 <= payload_len;
			element_s1     <= element;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			bytes_done_q   <= 7'd0;
			running_sum_q  <= 8'd0;
			frame_length_q <= 7'd0;
		end else if (load) begin
			if (close) begin
				in_frame_q     <= 1'b0;
				bytes_done_q   <= 7'd0;
				running_sum_q  <= 8'd0;
				frame_length_q <= 7'd0;
			end else begin
				in_frame_q     <= 1'b1;
				bytes_done_q   <= bdone + {4'd0, eb};
				running_sum_q  <= sum1;
				frame_length_q <= flen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			close_q <= 1'b0;
		end else if (load) begin
			count_q <= count_d;
			close_q <= close;
		end else if (take) begin
			count_q <= count_q - tfb_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= buf_d;
		end else if (take) begin
			for (int i = 0; i < tfb_pkg::MAX_RESULTS - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[tfb_pkg::MAX_RESULTS-1] <= 8'd0;
		end
	end

endmodule

/* src/tfb_checker.sv */
// Port-level checker for the telemetry frame builder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        frame_end,
	input logic        run_last
);

	logic end_taken;

	assign end_taken = out_valid && !out_stall && frame_end;

	// A stalled input transfer stays on offer.
	`ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid)

	// A stalled byte stays on offer unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte))

	// The checksum is always the last byte of the item that closes the frame.
	`ASSERT_SAME(a_end_is_last, clk, arst_n, out_valid && frame_end, run_last)

	// The bytes of one item follow each other without gaps.
	`ASSERT_NEXT(a_run_contig, clk, arst_n, out_valid && !out_stall && !run_last, out_valid)

	// A byte right after a checksum opens the next frame with a header byte.
	`ASSERT_NEXT(a_header_next, clk, arst_n, end_taken, !out_valid || (out_byte == 8'hAA))

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.frame_end (frame_end),
	.run_last  (run_last)
);
